FILE: hdl/hack_cpu_instruction_step_unit_macros.svh
// Assertion helpers shared by the step unit modules.
// Every module that uses them has a clock named clk_i and an active-low reset rst_ni.
`ifndef HACK_CPU_INSTRUCTION_STEP_UNIT_MACROS_SVH
`define HACK_CPU_INSTRUCTION_STEP_UNIT_MACROS_SVH

// Same-cycle implication.
`define HCPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HCPU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hcpu_pkg.sv
package hcpu_pkg;

  localparam int unsigned WordW       = 16;
  localparam int unsigned PcW         = 15;
  localparam int unsigned RamWordsDef = 32768;

  // Program length after reset: the whole instruction space.
  localparam logic [WordW-1:0] ProgWordsRst = 16'h8000;

  // Instruction fields.
  localparam int unsigned InsTypeBit = 15;
  localparam int unsigned InsAmBit   = 12;
  localparam int unsigned CompHi     = 11;
  localparam int unsigned CompLo     = 6;

  // Bits of the comp field.
  localparam int unsigned CompZx = 5;
  localparam int unsigned CompNx = 4;
  localparam int unsigned CompZy = 3;
  localparam int unsigned CompNy = 2;
  localparam int unsigned CompF  = 1;
  localparam int unsigned CompNo = 0;

  // Destination bits.
  localparam int unsigned DstA = 5;
  localparam int unsigned DstD = 4;
  localparam int unsigned DstM = 3;

  // Jump condition bits.
  localparam int unsigned JmpLt = 2;
  localparam int unsigned JmpEq = 1;
  localparam int unsigned JmpGt = 0;

  typedef struct packed {
    logic           en;
    logic [PcW-1:0] addr;
  } hcpu_rd_t;

  typedef struct packed {
    logic             en;
    logic [PcW-1:0]   addr;
    logic [WordW-1:0] data;
  } hcpu_wr_t;

  typedef struct packed {
    logic [PcW-1:0]   next_pc;
    logic [WordW-1:0] a_value;
    logic [WordW-1:0] d_value;
    logic             mem_write;
    logic [PcW-1:0]   mem_address;
    logic [WordW-1:0] mem_data;
    logic             finished;
  } hcpu_res_t;

endpackage

FILE: hdl/hack_cpu_instruction_step_unit.sv
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_stall_o      instruction_i, stop_i
// out       output     out_valid_o / out_stall_i    next_pc, a_value, d_value, mem_write,
//                                                   mem_address, mem_data, finished
// cfg       input      cfg_we_i                     cfg_wdata_i (program length in words)
//
// One instruction is taken per clock. A transfer on the input registers the
// instruction and launches the M read from the data RAM; the next cycle the
// instruction executes against that read data and its result moves into the
// output register, so the throughput is one item per cycle. After reset the
// data RAM is swept to zero one word per cycle, which holds the input stalled
// until the sweep has cleared every word. A stalled output holds the
// executing instruction, and in turn the input, until the result leaves.
`include "hack_cpu_instruction_step_unit_macros.svh"

module hack_cpu_instruction_step_unit #(
  parameter int unsigned RAM_WORDS = hcpu_pkg::RamWordsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hcpu_pkg::WordW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hcpu_pkg::WordW-1:0]   instruction_i,
  input  logic                         stop_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hcpu_pkg::PcW-1:0]     next_pc_o,
  output logic [hcpu_pkg::WordW-1:0]   a_value_o,
  output logic [hcpu_pkg::WordW-1:0]   d_value_o,
  output logic                         mem_write_o,
  output logic [hcpu_pkg::PcW-1:0]     mem_address_o,
  output logic [hcpu_pkg::WordW-1:0]   mem_data_o,
  output logic                         finished_o
);
  import hcpu_pkg::*;

  logic             clr_busy;
  logic             ex_valid;
  logic             ex_fire;
  logic             in_accept;
  logic [WordW-1:0] m_data;
  hcpu_rd_t         rd;
  hcpu_wr_t         wr;
  hcpu_res_t        res;
  hcpu_res_t        out_res_q;
  logic             out_valid_q;

  // The executing instruction retires whenever the output register is free
  // or is being emptied in this cycle; a new instruction can enter behind it
  // in the same cycle.
  assign ex_fire    = ex_valid && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy || (ex_valid && !ex_fire);
  assign in_accept  = in_valid_i && !in_stall_o;

  hcpu_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (in_accept),
    .instruction_i (instruction_i),
    .stop_i        (stop_i),
    .fire_i        (ex_fire),
    .m_data_i      (m_data),
    .ex_valid_o    (ex_valid),
    .res_o         (res),
    .rd_o          (rd),
    .wr_o          (wr)
  );

  hcpu_dmem #(
    .RamWords (RAM_WORDS)
  ) u_dmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (rd),
    .wr_i       (wr),
    .rdata_o    (m_data),
    .clr_busy_o (clr_busy)
  );

  // Output register: parts the execute stage from the consumer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = out_res_q.next_pc;
  assign a_value_o     = out_res_q.a_value;
  assign d_value_o     = out_res_q.d_value;
  assign mem_write_o   = out_res_q.mem_write;
  assign mem_address_o = out_res_q.mem_address;
  assign mem_data_o    = out_res_q.mem_data;
  assign finished_o    = out_res_q.finished;

  `HCPU_ASSERT_NXT(a_accept_enters_ex, in_accept, ex_valid,
                   "accepted instruction did not reach execute")
  `HCPU_ASSERT_NXT(a_fire_fills_out, ex_fire, out_valid_q,
                   "retired instruction produced no result")

endmodule

FILE: hdl/hcpu_dmem.sv
`include "hack_cpu_instruction_step_unit_macros.svh"

module hcpu_dmem #(
  parameter int unsigned RamWords = hcpu_pkg::RamWordsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hcpu_pkg::hcpu_rd_t            rd_i,
  input  hcpu_pkg::hcpu_wr_t            wr_i,
  output logic [hcpu_pkg::WordW-1:0]    rdata_o,
  output logic                          clr_busy_o
);
  import hcpu_pkg::*;

  localparam int unsigned IdxW = $clog2(RamWords);
  localparam logic [PcW:0] RamLimit = (PcW + 1)'(RamWords);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RamWords - 1);

  logic [WordW-1:0] mem_q [RamWords];
  logic [WordW-1:0] rdata_q;
  logic [WordW-1:0] fwd_data_q;
  logic             fwd_q;
  logic             oor_q;
  logic [IdxW-1:0]  clr_idx_q;
  logic             clr_busy_q;

  logic             rd_in_range;
  logic             wr_in_range;
  logic             mem_we;
  logic [IdxW-1:0]  mem_widx;
  logic [WordW-1:0] mem_wdata;
  logic             fwd_hit;

  always_comb begin
    rd_in_range = {1'b0, rd_i.addr} < RamLimit;
    wr_in_range = {1'b0, wr_i.addr} < RamLimit;
    fwd_hit     = wr_i.en && (wr_i.addr == rd_i.addr);
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_widx  = clr_idx_q;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_i.en && wr_in_range;
      mem_widx  = wr_i.addr[IdxW-1:0];
      mem_wdata = wr_i.data;
    end
  end

  // The array sees its old contents on a same-address read, so a store in
  // the same cycle is bypassed around it.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_widx] <= mem_wdata;
    end
    if (rd_i.en) begin
      rdata_q    <= mem_q[rd_i.addr[IdxW-1:0]];
      fwd_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      oor_q      <= 1'b0;
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      if (rd_i.en) begin
        fwd_q <= fwd_hit;
        oor_q <= !rd_in_range;
      end
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == LastIdx) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  assign rdata_o    = oor_q ? '0 : (fwd_q ? fwd_data_q : rdata_q);
  assign clr_busy_o = clr_busy_q;

  `HCPU_ASSERT_IMP(a_no_store_in_clear, clr_busy_q, !wr_i.en, "store during RAM clear")
  `HCPU_ASSERT_IMP(a_no_read_in_clear, clr_busy_q, !rd_i.en, "read during RAM clear")

endmodule

FILE: hdl/hcpu_core.sv
`include "hack_cpu_instruction_step_unit_macros.svh"

module hcpu_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hcpu_pkg::WordW-1:0]    cfg_wdata_i,
  input  logic                          accept_i,
  input  logic [hcpu_pkg::WordW-1:0]    instruction_i,
  input  logic                          stop_i,
  input  logic                          fire_i,
  input  logic [hcpu_pkg::WordW-1:0]    m_data_i,
  output logic                          ex_valid_o,
  output hcpu_pkg::hcpu_res_t           res_o,
  output hcpu_pkg::hcpu_rd_t            rd_o,
  output hcpu_pkg::hcpu_wr_t            wr_o
);
  import hcpu_pkg::*;

  logic [WordW-1:0] prog_words_q;
  logic [WordW-1:0] a_q;
  logic [WordW-1:0] d_q;
  logic [PcW-1:0]   pc_q;
  logic             stopped_q;
  logic             ex_valid_q;
  logic [WordW-1:0] ex_ins_q;
  logic             ex_stop_q;

  logic             halted;
  logic [5:0]       comp;
  logic [WordW-1:0] alu_x;
  logic [WordW-1:0] alu_y;
  logic [WordW-1:0] bus;
  logic             zr;
  logic             ng;
  logic             take;
  logic [PcW-1:0]   pc_inc;
  logic             store;
  hcpu_res_t        res;

  always_comb begin
    halted = ex_stop_q || stopped_q || ({1'b0, pc_q} >= prog_words_q);
    comp   = ex_ins_q[CompHi:CompLo];
    pc_inc = pc_q + 1'b1;

    alu_x = d_q;
    alu_y = ex_ins_q[InsAmBit] ? m_data_i : a_q;
    if (comp[CompZx]) alu_x = '0;
    if (comp[CompNx]) alu_x = ~alu_x;
    if (comp[CompZy]) alu_y = '0;
    if (comp[CompNy]) alu_y = ~alu_y;
    bus = comp[CompF] ? (alu_x + alu_y) : (alu_x & alu_y);
    if (comp[CompNo]) bus = ~bus;
    zr   = (bus == '0);
    ng   = bus[WordW-1];
    take = (ex_ins_q[JmpLt] && ng) || (ex_ins_q[JmpEq] && zr) ||
           (ex_ins_q[JmpGt] && !zr && !ng);

    res       = '0;
    store     = 1'b0;
    res.a_value = a_q;
    res.d_value = d_q;
    if (halted) begin
      res.next_pc  = pc_q;
      res.finished = 1'b1;
    end else begin
      res.next_pc = pc_inc;
      if (!ex_ins_q[InsTypeBit]) begin
        res.a_value = ex_ins_q;
      end else begin
        store = ex_ins_q[DstM];
        if (ex_ins_q[DstA]) res.a_value = bus;
        if (ex_ins_q[DstD]) res.d_value = bus;
        if (take) res.next_pc = a_q[PcW-1:0];
        if (store) begin
          res.mem_write   = 1'b1;
          res.mem_address = a_q[PcW-1:0];
          res.mem_data    = bus;
        end
      end
      res.finished = {1'b0, res.next_pc} >= prog_words_q;
    end
  end

  // The operand read for the incoming instruction uses A as it will be
  // once the instruction now executing has retired.
  always_comb begin
    rd_o.en   = accept_i;
    rd_o.addr = fire_i ? res.a_value[PcW-1:0] : a_q[PcW-1:0];
    wr_o.en   = fire_i && ex_valid_q && store;
    wr_o.addr = a_q[PcW-1:0];
    wr_o.data = bus;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_words_q <= ProgWordsRst;
      a_q          <= '0;
      d_q          <= '0;
      pc_q         <= '0;
      stopped_q    <= 1'b0;
      ex_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        prog_words_q <= cfg_wdata_i;
      end
      if (fire_i && ex_valid_q) begin
        a_q       <= res.a_value;
        d_q       <= res.d_value;
        pc_q      <= res.next_pc;
        stopped_q <= stopped_q || ex_stop_q;
      end
      if (accept_i) begin
        ex_valid_q <= 1'b1;
      end else if (fire_i) begin
        ex_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ex_ins_q  <= instruction_i;
      ex_stop_q <= stop_i;
    end
  end

  assign ex_valid_o = ex_valid_q;
  assign res_o      = res;

  `HCPU_ASSERT_IMP(a_store_on_fire, wr_o.en, fire_i && ex_valid_q && !halted,
                   "RAM store without a retiring instruction")
  `HCPU_ASSERT_NXT(a_stop_sticks, fire_i && ex_valid_q && ex_stop_q, stopped_q,
                   "stop request did not halt the CPU")

endmodule
